/* rtl/core/virtio_pci_common_config_regs_top_defines.svh */
// Assertion macros shared by the common configuration register window.
`ifndef VIRTIO_PCI_COMMON_CONFIG_REGS_TOP_DEFINES_SVH
`define VIRTIO_PCI_COMMON_CONFIG_REGS_TOP_DEFINES_SVH

// Checks that a condition holds at every clock edge outside reset.
`define VPCC_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Checks that a trigger is followed by a consequence in the next cycle.
`define VPCC_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/vpcc_pkg.sv */
// Types and register map constants of the virtio common configuration window.
package vpcc_pkg;

  localparam logic OpRead  = 1'b0;
  localparam logic OpWrite = 1'b1;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgDeviceFeatures  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgQueueCount      = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgConfigGeneration = 2'd2;

  localparam logic [7:0] OffDevFeatSel   = 8'h00;
  localparam logic [7:0] OffDevFeat      = 8'h04;
  localparam logic [7:0] OffDrvFeatSel   = 8'h08;
  localparam logic [7:0] OffDrvFeat      = 8'h0C;
  localparam logic [7:0] OffMsixConfig   = 8'h10;
  localparam logic [7:0] OffNumQueues    = 8'h12;
  localparam logic [7:0] OffDevStatus    = 8'h14;
  localparam logic [7:0] OffCfgGen       = 8'h15;
  localparam logic [7:0] OffQueueSel     = 8'h16;
  localparam logic [7:0] OffQueueSize    = 8'h18;
  localparam logic [7:0] OffQueueMsix    = 8'h1A;
  localparam logic [7:0] OffQueueEnable  = 8'h1C;
  localparam logic [7:0] OffQueueNotify  = 8'h1E;
  localparam logic [7:0] OffQueueDescLo  = 8'h20;
  localparam logic [7:0] OffQueueDescHi  = 8'h24;
  localparam logic [7:0] OffQueueAvailLo = 8'h28;
  localparam logic [7:0] OffQueueAvailHi = 8'h2C;
  localparam logic [7:0] OffQueueUsedLo  = 8'h30;
  localparam logic [7:0] OffQueueUsedHi  = 8'h34;

  // Only bit 0 of the queue enable register is kept.
  localparam logic [31:0] EnableBit = 32'h0000_0001;

  typedef struct packed {
    logic        op;
    logic [7:0]  offset;
    logic [31:0] wr_word;
  } req_t;

  typedef struct packed {
    logic [31:0] rd_word;
    logic        unsupported;
  } rsp_t;

endpackage

/* rtl/core/virtio_pci_common_config_regs_top.sv */
// Common configuration register window of a virtio modern PCI device.
//
//   Channel   Direction  Signals                          Moves
//   req       in         req_valid_i, req_ready_o, req_i   one bus read or write request
//   rsp       out        rsp_valid_o, rsp_ready_i, rsp_o   one response per request
//   cfg       in         cfg_valid_i, cfg_ready_o, ...     device side register writes
//
// A request is taken into an input register when accepted; when it leaves that register it is
// decoded and applied to the register file, and its response is loaded into the output
// register, which offers it from then on. One request per cycle is sustained while rsp is not
// stalled; the single decode stage between the two registers sets that rate.
// Both stages advance whenever the output register is empty or being drained, so a stall
// on rsp backs up one stage at a time. Reset clears the valid flags, the device features and
// config generation (queue_count resets to 1) and every driver visible register, including all
// per-queue entries, at once; the data of the two pipeline registers is not reset.
`include "virtio_pci_common_config_regs_top_defines.svh"

module virtio_pci_common_config_regs_top
  import vpcc_pkg::*;
#(
  parameter int unsigned MAX_QUEUES = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  req_t               req_i,
  output logic               rsp_valid_o,
  input  logic               rsp_ready_i,
  output rsp_t               rsp_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  // Width of a queue index; a single queue still gets one bit.
  localparam int unsigned QW = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;

  // Device side configuration.
  logic [31:0] device_features_q;
  logic [3:0]  queue_count_q;
  logic [7:0]  config_generation_q;

  // Driver visible registers.
  logic [31:0] dev_feature_sel_q;
  logic [31:0] drv_feature_sel_q;
  logic [31:0] drv_features_q;
  logic [7:0]  device_status_q;
  logic [15:0] queue_sel_q;
  logic [15:0] queue_size_q   [MAX_QUEUES];
  logic        queue_enable_q [MAX_QUEUES];
  logic [31:0] desc_lo_q      [MAX_QUEUES];
  logic [31:0] desc_hi_q      [MAX_QUEUES];
  logic [31:0] avail_lo_q     [MAX_QUEUES];
  logic [31:0] avail_hi_q     [MAX_QUEUES];
  logic [31:0] used_lo_q      [MAX_QUEUES];
  logic [31:0] used_hi_q      [MAX_QUEUES];

  // Pipeline registers.
  logic req_valid_q;
  req_t req_q;
  logic rsp_valid_q;
  rsp_t rsp_q;

  // Handshake. The decode stage moves on whenever the output register can take a result.
  logic stage_adv;
  logic req_fire;
  assign stage_adv   = !rsp_valid_q || rsp_ready_i;
  assign req_ready_o = !req_valid_q || stage_adv;
  assign req_fire    = req_valid_i && req_ready_o;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;
  assign cfg_ready_o = 1'b1;

  // Decode of the registered request.
  logic          is_wr;
  logic          per_queue;
  logic          queue_ok;
  logic [QW-1:0] qidx;
  logic          bad;
  logic [31:0]   rd_data;

  assign is_wr = (req_q.op == OpWrite);
  assign qidx  = queue_sel_q[QW-1:0];

  // The selected queue is in range when it is below both queue_count and the queue storage.
  assign queue_ok = (queue_sel_q < {12'd0, queue_count_q}) &&
                    (queue_sel_q < 16'(MAX_QUEUES));

  always_comb begin
    per_queue = req_q.offset inside {OffQueueSize, OffQueueEnable, OffQueueNotify,
                                     OffQueueDescLo, OffQueueDescHi, OffQueueAvailLo,
                                     OffQueueAvailHi, OffQueueUsedLo, OffQueueUsedHi};
    bad     = per_queue && !queue_ok;
    rd_data = '0;
    case (req_q.offset)
      OffDevFeatSel:   rd_data = dev_feature_sel_q;
      OffDevFeat:      rd_data = device_features_q;
      OffDrvFeatSel:   rd_data = drv_feature_sel_q;
      OffDrvFeat:      rd_data = drv_features_q;
      OffNumQueues:    rd_data = {28'd0, queue_count_q};
      OffDevStatus:    rd_data = {24'd0, device_status_q};
      OffCfgGen:       rd_data = {24'd0, config_generation_q};
      OffQueueSel:     rd_data = {16'd0, queue_sel_q};
      OffQueueSize:    rd_data = {16'd0, queue_size_q[qidx]};
      OffQueueEnable:  rd_data = {31'd0, queue_enable_q[qidx]};
      OffQueueNotify:  rd_data = {16'd0, queue_sel_q};
      OffQueueDescLo:  rd_data = desc_lo_q[qidx];
      OffQueueDescHi:  rd_data = desc_hi_q[qidx];
      OffQueueAvailLo: rd_data = avail_lo_q[qidx];
      OffQueueAvailHi: rd_data = avail_hi_q[qidx];
      OffQueueUsedLo:  rd_data = used_lo_q[qidx];
      OffQueueUsedHi:  rd_data = used_hi_q[qidx];
      // MSI-X offsets and everything unmapped are unsupported.
      default:         bad = 1'b1;
    endcase
  end

  // A write only lands when the request is supported and actually leaves the decode stage.
  logic do_write;
  assign do_write = req_valid_q && stage_adv && is_wr && !bad;

  // Input and output registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (req_ready_o) begin
        req_valid_q <= req_valid_i;
      end
      if (stage_adv) begin
        rsp_valid_q <= req_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      req_q <= req_i;
    end
    if (stage_adv && req_valid_q) begin
      rsp_q.rd_word     <= (is_wr || bad) ? 32'd0 : rd_data;
      rsp_q.unsupported <= bad;
    end
  end

  // Device side configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_features_q   <= '0;
      queue_count_q       <= 4'd1;
      config_generation_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgDeviceFeatures:   device_features_q   <= cfg_data_i;
        CfgQueueCount:       queue_count_q       <= cfg_data_i[3:0];
        CfgConfigGeneration: config_generation_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Global driver registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_feature_sel_q <= '0;
      drv_feature_sel_q <= '0;
      drv_features_q    <= '0;
      device_status_q   <= '0;
      queue_sel_q       <= '0;
    end else if (do_write) begin
      case (req_q.offset)
        OffDevFeatSel: dev_feature_sel_q <= req_q.wr_word;
        OffDrvFeatSel: drv_feature_sel_q <= req_q.wr_word;
        OffDrvFeat:    drv_features_q    <= req_q.wr_word;
        OffDevStatus:  device_status_q   <= req_q.wr_word[7:0];
        OffQueueSel:   queue_sel_q       <= req_q.wr_word[15:0];
        default: ;
      endcase
    end
  end

  // Per-queue registers, addressed through the queue select.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_QUEUES; i++) begin
        queue_size_q[i]   <= '0;
        queue_enable_q[i] <= 1'b0;
        desc_lo_q[i]      <= '0;
        desc_hi_q[i]      <= '0;
        avail_lo_q[i]     <= '0;
        avail_hi_q[i]     <= '0;
        used_lo_q[i]      <= '0;
        used_hi_q[i]      <= '0;
      end
    end else if (do_write) begin
      case (req_q.offset)
        OffQueueSize:    queue_size_q[qidx]   <= req_q.wr_word[15:0];
        OffQueueEnable:  queue_enable_q[qidx] <= |(req_q.wr_word & EnableBit);
        OffQueueDescLo:  desc_lo_q[qidx]      <= req_q.wr_word;
        OffQueueDescHi:  desc_hi_q[qidx]      <= req_q.wr_word;
        OffQueueAvailLo: avail_lo_q[qidx]     <= req_q.wr_word;
        OffQueueAvailHi: avail_hi_q[qidx]     <= req_q.wr_word;
        OffQueueUsedLo:  used_lo_q[qidx]      <= req_q.wr_word;
        OffQueueUsedHi:  used_hi_q[qidx]      <= req_q.wr_word;
        default: ;
      endcase
    end
  end

  // Short terms for the checks below.
  logic rsp_bad;
  logic dec_stall;
  logic dec_fire;
  logic dec_msix;
  assign rsp_bad   = rsp_valid_o && rsp_o.unsupported;
  assign dec_stall = req_valid_q && !stage_adv;
  assign dec_fire  = req_valid_q && stage_adv;
  assign dec_msix  = (req_q.offset == OffMsixConfig) || (req_q.offset == OffQueueMsix);

  // An unsupported response never carries data.
  `VPCC_ASSERT(a_bad_zero, !rsp_bad || (rsp_o.rd_word == '0), "unsupported response carries data")
  // A request held in the decode stage is neither dropped nor doubled while the output stalls.
  `VPCC_ASSERT_NEXT(a_stage_hold, dec_stall, req_valid_q && $stable(req_q), "request lost")
  // A request leaving the decode stage always produces a response.
  `VPCC_ASSERT_NEXT(a_rsp_made, dec_fire, rsp_valid_o, "request left decode without a response")
  // MSI-X offsets are always flagged.
  `VPCC_ASSERT_NEXT(a_msix_bad, dec_fire && dec_msix, rsp_o.unsupported, "MSI-X access not flagged")

endmodule
